### rtl/core/kmne_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmne_pkg: shared constants, types and tables of the key matrix scanner
// Matrix geometry, field widths, item action codes and the power-up note
// layout of the note map.
// ----------------------------------------------------------------------------
package kmne_pkg;

  // Matrix geometry
  localparam int COLUMNS  = 14;
  localparam int ROWS     = 4;
  localparam int MAP_SIZE = ROWS * COLUMNS;

  // Field widths
  localparam int COL_W   = 4;
  localparam int ROW_W   = 2;
  localparam int LEVEL_W = 4;
  localparam int IDX_W   = 6;
  localparam int NOTE_W  = 7;
  localparam int VEL_W   = 7;

  // Velocities
  localparam logic [VEL_W-1:0] VEL_ON  = 7'd127;
  localparam logic [VEL_W-1:0] VEL_OFF = 7'd0;

  // Input item action codes
  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_SCAN = 1'b1
  } action_t;

  // Power-up note layout, row by column
  localparam int DEF_ROWS = 4;
  localparam int DEF_COLS = 14;

  localparam logic [NOTE_W-1:0] DEF_LAYOUT [DEF_ROWS][DEF_COLS] = '{
    '{7'd54, 7'd50, 7'd61, 7'd71, 7'd81, 7'd78, 7'd88,
      7'd90, 7'd93, 7'd82, 7'd72, 7'd62, 7'd51, 7'd55},
    '{7'd68, 7'd64, 7'd75, 7'd84, 7'd95, 7'd92, 7'd56,
      7'd75, 7'd79, 7'd68, 7'd59, 7'd48, 7'd96, 7'd87},
    '{7'd80, 7'd77, 7'd87, 7'd53, 7'd51, 7'd60, 7'd70,
      7'd63, 7'd65, 7'd56, 7'd89, 7'd80, 7'd83, 7'd73},
    '{7'd94, 7'd91, 7'd57, 7'd67, 7'd63, 7'd74, 7'd85,
      7'd49, 7'd52, 7'd86, 7'd76, 7'd66, 7'd69, 7'd58}
  };

  // Note of a map entry that was never loaded
  function automatic logic [NOTE_W-1:0] default_note(input logic [ROW_W-1:0] row,
                                                     input logic [COL_W-1:0] col);
    logic [NOTE_W-1:0] note;
    note = '0;
    if (int'(row) < DEF_ROWS && int'(col) < DEF_COLS) begin
      note = DEF_LAYOUT[int'(row)][int'(col)];
    end
    return note;
  endfunction

endpackage
`default_nettype wire

### rtl/core/kmne_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmne_in_if: input item channel
// Valid/ready channel carrying one scan or note map load item per transfer.
// ----------------------------------------------------------------------------
interface kmne_in_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [kmne_pkg::LEVEL_W-1:0] row_levels;
  logic [kmne_pkg::IDX_W-1:0]   load_index;
  logic [kmne_pkg::NOTE_W-1:0]  load_note;

  modport source (output valid, action, row_levels, load_index, load_note,
                  input ready);
  modport sink   (input valid, action, row_levels, load_index, load_note,
                  output ready);
endinterface
`default_nettype wire

### rtl/core/kmne_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmne_out_if: note event channel
// Valid/ready channel carrying one note event per transfer.
// ----------------------------------------------------------------------------
interface kmne_out_if;
  logic                        valid;
  logic                        ready;
  logic [kmne_pkg::COL_W-1:0]  column_index;
  logic [kmne_pkg::ROW_W-1:0]  row_index;
  logic [kmne_pkg::NOTE_W-1:0] note_number;
  logic [kmne_pkg::VEL_W-1:0]  velocity;
  logic                        last;

  modport source (output valid, column_index, row_index, note_number, velocity, last,
                  input ready);
  modport sink   (input valid, column_index, row_index, note_number, velocity, last,
                  output ready);
endinterface
`default_nettype wire

### rtl/core/kmne_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmne_ram: generic simple dual-port RAM
// One write port, one read port with registered read data. A read of the
// address being written returns the old contents. Read data holds while
// no read is enabled.
// ----------------------------------------------------------------------------
module kmne_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire               clk,
  input  wire               we,
  input  wire  [ADDR_W-1:0] waddr,
  input  wire  [WIDTH-1:0]  wdata,
  input  wire               re,
  input  wire  [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### rtl/core/key_matrix_note_events.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// key_matrix_note_events: key matrix scanner with note event output
// Compares scanned row levels with the stored switch state and emits one
// note event per changed key.
// ----------------------------------------------------------------------------
// Usage
//   in_ch  : one item per transfer. A scan item (action = 1) carries the
//            row levels of the current column (low = pressed); a load item
//            (action = 0) writes one note map entry.
//   out_ch : one note event per transfer, rows in ascending order, the last
//            event of a scan marked with last.
//   cfg_we / cfg_wdata : writes scan_enable; scans are dropped while it is 0.
// Throughput
//   A scan's events pass the compare stage, event sequencer, note read
//   stage and output register to out_ch, one per cycle while out_ch.ready
//   is high. Scans without a key change and loads are taken every cycle
//   while the compare stage is free; a scan with changes holds the event
//   sequencer, and so the input, until the single note map read port has
//   served them. A load waits until all earlier events have read their note.
// Reset
//   Synchronous rst_n: all keys up, default note layout, column 0, scanning
//   off. No clearing pass: per-entry valid bits stand for the reset values.
// Stall
//   When out_ch.ready is low the events back up through the note read stage
//   and the sequencer; in_ch.ready drops once the compare stage is full.
// ----------------------------------------------------------------------------
module key_matrix_note_events (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        cfg_we,
  input  wire        cfg_wdata,
  kmne_in_if.sink    in_ch,
  kmne_out_if.source out_ch
);

  localparam int ROWS    = kmne_pkg::ROWS;
  localparam int COLUMNS = kmne_pkg::COLUMNS;
  localparam int COL_W   = kmne_pkg::COL_W;
  localparam int ROW_W   = kmne_pkg::ROW_W;
  localparam int IDX_W   = kmne_pkg::IDX_W;
  localparam int NOTE_W  = kmne_pkg::NOTE_W;

  // Configuration and column counter
  logic             scan_en_r;
  logic [COL_W-1:0] col_r, col_nxt;

  // Compare stage
  logic             b_valid_r, b_valid_nxt;
  logic [COL_W-1:0] b_col_r;
  logic [ROWS-1:0]  b_press_r, b_press_nxt;
  logic             b_fwd_r, b_fwd_nxt;
  logic [ROWS-1:0]  b_fwd_data_r;
  logic [ROWS-1:0]  b_stored, b_change;
  logic             b_moves, b_free;

  // Event sequencer
  logic [ROWS-1:0]  ev_mask_r, ev_mask_nxt;
  logic [ROWS-1:0]  ev_press_r;
  logic [COL_W-1:0] ev_col_r;
  logic [ROWS-1:0]  ev_onehot;
  logic [ROW_W-1:0] ev_row;
  logic             ev_last, ev_issue, ev_empty_nxt;
  logic [IDX_W-1:0] ev_addr;

  // Note read stage
  logic              p_valid_r, p_valid_nxt;
  logic [COL_W-1:0]  p_col_r;
  logic [ROW_W-1:0]  p_row_r;
  logic              p_press_r, p_last_r, p_vb_r;
  logic [NOTE_W-1:0] p_def_r, p_note;
  logic              p_moves, p_free;

  // Output register
  logic              o_valid_r, o_valid_nxt;
  logic [COL_W-1:0]  o_col_r;
  logic [ROW_W-1:0]  o_row_r;
  logic [NOTE_W-1:0] o_note_r;
  logic              o_press_r, o_last_r;

  // Valid bits standing for reset contents of the memories
  logic [COLUMNS-1:0]           sw_vld_r;
  logic [kmne_pkg::MAP_SIZE-1:0] nm_vld_r;

  // Memory ports
  logic [ROWS-1:0]   sw_rdata;
  logic [NOTE_W-1:0] nm_rdata;

  // Input decode
  logic in_scan, in_fire, scan_go, load_go, load_ok;

  assign in_scan = (in_ch.action == kmne_pkg::ACT_SCAN);
  assign in_fire = in_ch.valid && in_ch.ready;
  assign scan_go = in_fire && in_scan && scan_en_r;
  assign load_go = in_fire && !in_scan &&
                   (in_ch.load_index < IDX_W'(kmne_pkg::MAP_SIZE));

  // Stored switch state of the column in the compare stage
  assign b_stored = b_fwd_r ? b_fwd_data_r : (sw_vld_r[b_col_r] ? sw_rdata : '0);
  assign b_change = b_press_r ^ b_stored;

  // Lowest pending row of the sequencer
  always_comb begin
    ev_onehot = '0;
    ev_row    = '0;
    for (int r = ROWS - 1; r >= 0; r--) begin
      if (ev_mask_r[r]) begin
        ev_onehot = ROWS'(1) << r;
        ev_row    = ROW_W'(r);
      end
    end
  end

  assign ev_last      = ((ev_mask_r & ~ev_onehot) == '0);
  assign ev_addr      = IDX_W'(32'(ev_row) * COLUMNS + 32'(ev_col_r));
  assign p_moves      = p_valid_r && (!o_valid_r || out_ch.ready);
  assign p_free       = !p_valid_r || p_moves;
  assign ev_issue     = (ev_mask_r != '0) && p_free;
  assign ev_empty_nxt = (ev_mask_r == '0) || (ev_issue && ev_last);
  assign b_moves      = b_valid_r && ((b_change == '0) || ev_empty_nxt);
  assign b_free       = !b_valid_r || b_moves;

  // A load may not overtake events still waiting for their note
  assign load_ok = !(b_valid_r && (b_change != '0)) &&
                   ((ev_mask_r & ~(ev_issue ? ev_onehot : '0)) == '0);

  assign in_ch.ready = b_free && (in_scan || load_ok);

  // Column counter and compare stage next state
  always_comb begin
    col_nxt = col_r;
    if (scan_go) begin
      col_nxt = (32'(col_r) >= COLUMNS - 1) ? '0 : col_r + COL_W'(1);
    end
    b_valid_nxt = scan_go ? 1'b1 : (b_moves ? 1'b0 : b_valid_r);
    b_fwd_nxt   = b_moves && (b_col_r == col_r);
    for (int r = 0; r < ROWS; r++) begin
      b_press_nxt[r] = (r < kmne_pkg::LEVEL_W) ? ~in_ch.row_levels[r] : 1'b0;
    end
  end

  // Sequencer, read stage and output next state
  always_comb begin
    ev_mask_nxt = ev_mask_r;
    if (b_moves && (b_change != '0)) begin
      ev_mask_nxt = b_change;
    end else if (ev_issue) begin
      ev_mask_nxt = ev_mask_r & ~ev_onehot;
    end
    p_valid_nxt = ev_issue ? 1'b1 : (p_moves ? 1'b0 : p_valid_r);
    o_valid_nxt = p_moves ? 1'b1 : (out_ch.ready ? 1'b0 : o_valid_r);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_en_r <= 1'b0;
      col_r     <= '0;
      b_valid_r <= 1'b0;
      ev_mask_r <= '0;
      p_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
      sw_vld_r  <= '0;
      nm_vld_r  <= '0;
    end else begin
      if (cfg_we) begin
        scan_en_r <= cfg_wdata;
      end
      col_r     <= col_nxt;
      b_valid_r <= b_valid_nxt;
      ev_mask_r <= ev_mask_nxt;
      p_valid_r <= p_valid_nxt;
      o_valid_r <= o_valid_nxt;
      if (b_moves) begin
        sw_vld_r[b_col_r] <= 1'b1;
      end
      if (load_go) begin
        nm_vld_r[in_ch.load_index] <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (scan_go) begin
      b_col_r      <= col_r;
      b_press_r    <= b_press_nxt;
      b_fwd_r      <= b_fwd_nxt;
      b_fwd_data_r <= b_press_r;
    end
    // only a scan with changes takes over the sequencer
    if (b_moves && (b_change != '0)) begin
      ev_col_r   <= b_col_r;
      ev_press_r <= b_press_r;
    end
    if (ev_issue) begin
      p_col_r   <= ev_col_r;
      p_row_r   <= ev_row;
      p_press_r <= ev_press_r[ev_row];
      p_last_r  <= ev_last;
      p_vb_r    <= nm_vld_r[ev_addr];
      p_def_r   <= kmne_pkg::default_note(ev_row, ev_col_r);
    end
    if (p_moves) begin
      o_col_r   <= p_col_r;
      o_row_r   <= p_row_r;
      o_note_r  <= p_note;
      o_press_r <= p_press_r;
      o_last_r  <= p_last_r;
    end
  end

  assign p_note = p_vb_r ? nm_rdata : p_def_r;

  // Switch state, one word of row bits per column
  kmne_ram #(
    .WIDTH (ROWS),
    .DEPTH (COLUMNS)
  ) u_switch_ram (
    .clk   (clk),
    .we    (b_moves),
    .waddr (b_col_r),
    .wdata (b_press_r),
    .re    (scan_go),
    .raddr (col_r),
    .rdata (sw_rdata)
  );

  // Note map, one entry per key
  kmne_ram #(
    .WIDTH (NOTE_W),
    .DEPTH (kmne_pkg::MAP_SIZE)
  ) u_note_ram (
    .clk   (clk),
    .we    (load_go),
    .waddr (in_ch.load_index),
    .wdata (in_ch.load_note),
    .re    (ev_issue),
    .raddr (ev_addr),
    .rdata (nm_rdata)
  );

  // Result channel
  assign out_ch.valid        = o_valid_r;
  assign out_ch.column_index = o_col_r;
  assign out_ch.row_index    = o_row_r;
  assign out_ch.note_number  = o_note_r;
  assign out_ch.velocity     = o_press_r ? kmne_pkg::VEL_ON : kmne_pkg::VEL_OFF;
  assign out_ch.last         = o_last_r;

endmodule
`default_nettype wire
